// File: hdl/psv_pkg.sv
// Shared constants, codes and types for the odd-window prime sieve.
// Used by psv_div, psv_sieve_ctrl and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package psv_pkg;

	localparam int WINDOW_ODDS    = 4096;
	localparam int NUMBER_BITS    = 32;
	localparam int MAP_AW         = $clog2(WINDOW_ODDS);
	localparam int COUNT_BITS     = MAP_AW + 1;
	// Divisors stop once their square passes the window end.
	localparam int DIVISOR_BITS   = NUMBER_BITS / 2 + 1;
	localparam int SQ_BITS        = NUMBER_BITS + 2;
	localparam int M_BITS         = NUMBER_BITS + 2;
	localparam int CFG_INDEX_BITS = 2;
	localparam int STATUS_BITS    = 2;

	localparam logic CMD_RUN   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_RANGE   = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_OUTSIDE = 2'd2;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_BEGIN = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_END   = 2'd1;

	localparam logic [NUMBER_BITS-1:0] BEGIN_RESET = NUMBER_BITS'(5);
	localparam logic [NUMBER_BITS-1:0] END_RESET   = NUMBER_BITS'(8195);
	localparam logic [NUMBER_BITS-1:0] MIN_BEGIN   = NUMBER_BITS'(3);
	localparam int FIRST_DIVISOR = 3;

	typedef struct packed {
		logic              we;
		logic [MAP_AW-1:0] addr;
		logic              data;
	} psv_wr_t;

	typedef struct packed {
		logic                   valid;
		logic [STATUS_BITS-1:0] status;
	} psv_done_t;

endpackage

`default_nettype wire

// File: hdl/psv_map_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the prime map; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module psv_map_ram #(
	parameter int ADDR_BITS = 12,
	parameter int DATA_BITS = 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/psv_div.sv
// Bit-serial remainder unit: dividend mod divisor, one quotient bit per cycle.
// Depends on psv_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module psv_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [psv_pkg::NUMBER_BITS-1:0]  dividend,
	input  logic [psv_pkg::DIVISOR_BITS-1:0] divisor,
	output logic                            done,
	output logic [psv_pkg::DIVISOR_BITS-1:0] rem
);
	import psv_pkg::*;

	localparam int CNT_W = $clog2(NUMBER_BITS + 1);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [NUMBER_BITS-1:0]  dvd_q;
	logic [DIVISOR_BITS-1:0] rem_q;
	logic [DIVISOR_BITS:0]   trial;
	logic [DIVISOR_BITS:0]   diff;
	logic                    fits;

	always_comb begin
		trial = {rem_q, dvd_q[NUMBER_BITS-1]};
		diff  = trial - {1'b0, divisor};
		fits  = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUMBER_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			// A trial that does not fit is already below the divisor.
			rem_q <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rem < divisor)
		else $error("remainder not below divisor");

endmodule

`default_nettype wire

// File: hdl/psv_sieve_ctrl.sv
// Sequencer for a run command: range check, map fill, then one pass of
// multiple clearing per odd divisor. Depends on psv_pkg and psv_div.
`timescale 1ns / 1ps
`default_nettype none

module psv_sieve_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [psv_pkg::NUMBER_BITS-1:0] range_begin,
	input  logic [psv_pkg::NUMBER_BITS-1:0] range_end,
	input  logic                           slot_free,
	output logic                           busy,
	output psv_pkg::psv_done_t             done,
	output psv_pkg::psv_wr_t               wr
);
	import psv_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_FILL   = 3'd2;
	localparam logic [2:0] S_LOOP   = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_SETUP  = 3'd5;
	localparam logic [2:0] S_CLEAR  = 3'd6;
	localparam logic [2:0] S_FINISH = 3'd7;

	logic [2:0]              state_q;
	logic [STATUS_BITS-1:0]  status_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [COUNT_BITS-1:0]   fill_q;
	logic [DIVISOR_BITS-1:0] i_q;
	logic [SQ_BITS-1:0]      isq_q;
	logic [M_BITS-1:0]       m_q;

	logic [NUMBER_BITS-1:0]  base;
	logic [NUMBER_BITS:0]    span;
	logic                    empty;
	logic [NUMBER_BITS-2:0]  half;
	logic                    too_many;
	logic                    bad;
	logic [COUNT_BITS-1:0]   count_next;
	logic                    sq_over;
	logic                    div_start;
	logic                    div_done;
	logic [DIVISOR_BITS-1:0] div_rem;
	logic [DIVISOR_BITS-1:0] adj;
	logic [M_BITS-1:0]       two_i;
	logic [M_BITS-1:0]       lo;
	logic [M_BITS-1:0]       end_m;
	logic                    m_over;
	logic [M_BITS-1:0]       off;
	logic                    off_ok;

	always_comb begin
		base       = range_begin | NUMBER_BITS'(1);
		span       = {1'b0, range_end} - {1'b0, base};
		empty      = span[NUMBER_BITS];
		half       = span[NUMBER_BITS-1:1];
		too_many   = !empty && (half >= (NUMBER_BITS-1)'(WINDOW_ODDS));
		bad        = (range_begin <= MIN_BEGIN) || (range_end < range_begin) || too_many;
		count_next = empty ? '0 : ({1'b0, half[MAP_AW-1:0]} + COUNT_BITS'(1));
		sq_over    = isq_q > SQ_BITS'(range_end);
		div_start  = (state_q == S_LOOP) && !sq_over;
		adj        = (div_rem == '0) ? '0 : (i_q - div_rem);
		two_i      = M_BITS'(i_q) << 1;
		lo         = (m_q < two_i) ? two_i : m_q;
		end_m      = M_BITS'(range_end);
		m_over     = m_q > end_m;
		off        = m_q - M_BITS'(base);
		off_ok     = off[M_BITS-1:MAP_AW+1] == '0;
	end

	psv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (range_begin),
		.divisor  (i_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= bad ? S_FINISH : S_FILL;
				end
				S_FILL: begin
					if (fill_q == count_q) begin
						state_q <= S_LOOP;
					end
				end
				S_LOOP: begin
					state_q <= sq_over ? S_FINISH : S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					state_q <= S_CLEAR;
				end
				S_CLEAR: begin
					if (m_over) begin
						state_q <= S_LOOP;
					end
				end
				S_FINISH: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_CHECK: begin
				status_q <= bad ? ST_RANGE : ST_OK;
				count_q  <= count_next;
				fill_q   <= '0;
				i_q      <= DIVISOR_BITS'(FIRST_DIVISOR);
				isq_q    <= SQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
			end
			S_FILL: begin
				if (fill_q != count_q) begin
					fill_q <= fill_q + COUNT_BITS'(1);
				end
			end
			S_DIV: begin
				// First multiple of the divisor at or above the window start.
				m_q <= M_BITS'(range_begin) + M_BITS'(adj);
			end
			S_SETUP: begin
				// Skip the divisor itself, then step onto an odd multiple.
				m_q <= lo[0] ? lo : (lo + M_BITS'(i_q));
			end
			S_CLEAR: begin
				if (m_over) begin
					i_q   <= i_q + DIVISOR_BITS'(2);
					isq_q <= isq_q + (SQ_BITS'(i_q) << 2) + SQ_BITS'(4);
				end else begin
					m_q <= m_q + two_i;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		wr = '0;
		if (state_q == S_FILL && fill_q != count_q) begin
			wr.we   = 1'b1;
			wr.addr = fill_q[MAP_AW-1:0];
			wr.data = 1'b1;
		end else if (state_q == S_CLEAR && !m_over && off_ok) begin
			wr.we   = 1'b1;
			wr.addr = off[MAP_AW:1];
			wr.data = 1'b0;
		end
	end

	assign busy         = state_q != S_IDLE;
	assign done.valid   = (state_q == S_FINISH) && slot_free;
	assign done.status  = status_q;

	a_clear_odd_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> i_q[0])
		else $error("sieve divisor is even");

	a_clear_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we && !wr.data |-> state_q == S_CLEAR && m_q <= end_m && m_q[0])
		else $error("map cleared outside the window");

endmodule

`default_nettype wire

// File: hdl/odd_window_prime_sieve.sv
// Top level of the odd-window prime sieve: handshakes, window registers,
// query path and result register. Depends on psv_pkg, psv_map_ram, psv_sieve_ctrl.
//
// Usage. Configuration writes set range_begin (index 0) and range_end (index 1);
// either write invalidates the map until the next run that ends with OK status.
// An input word with command 0 runs the sieve, command 1 queries query_value.
// Every input word gives one output word (is_prime, status), in order.
// Queries: accepted every cycle while no run is active and the read stage
// is free to advance; the result passes through the map read stage and
// then the output register.
// Runs: a range check, a fill of the map over each odd entry of the window,
// then for each odd divisor i with i*i <= range_end a bit-serial remainder
// for the first multiple plus setup, and a clear of each odd multiple of i
// inside the window. The map memory has one write port, so fills and clears
// are written one at a time. Input is stalled for the whole run.
// Reset: window registers return to 5..8195, the map is marked invalid and
// the map contents are left as they are; every run refills the window before
// any query is answered, so no clearing pass follows reset.
// A stalled receiver holds the output word; one more word waits in the
// read stage, after which in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module odd_window_prime_sieve (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               command,
	input  logic [psv_pkg::NUMBER_BITS-1:0]     query_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               is_prime,
	output logic [psv_pkg::STATUS_BITS-1:0]     status,
	input  logic                               cfg_write,
	input  logic [psv_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [psv_pkg::NUMBER_BITS-1:0]     cfg_data
);
	import psv_pkg::*;

	logic [NUMBER_BITS-1:0] begin_q;
	logic [NUMBER_BITS-1:0] end_q;
	logic                   win_valid_q;
	logic                   valid_s1;
	logic [STATUS_BITS-1:0] status_s1;
	logic                   odd_s1;
	logic                   out_valid_q;
	logic                   is_prime_q;
	logic [STATUS_BITS-1:0] status_q;

	logic                   accept;
	logic                   q_acc;
	logic                   run_acc;
	logic                   in_win;
	logic [NUMBER_BITS-1:0] qoff;
	logic                   rd_en;
	logic                   rd_data;
	logic                   adv;
	logic                   slot_free;
	logic                   ctrl_busy;
	logic                   cfg_hit;
	psv_done_t              done;
	psv_wr_t                wr;

	always_comb begin
		adv       = valid_s1 && (!out_valid_q || !out_stall);
		slot_free = !valid_s1 || adv;
		in_stall  = ctrl_busy || !slot_free;
		accept    = in_valid && !in_stall;
		q_acc     = accept && (command == CMD_QUERY);
		run_acc   = accept && (command == CMD_RUN);
		in_win    = win_valid_q && (query_value >= begin_q) && (query_value <= end_q);
		qoff      = query_value - (begin_q | NUMBER_BITS'(1));
		rd_en     = q_acc && in_win && query_value[0];
		cfg_hit   = cfg_write && (cfg_index == CFG_BEGIN || cfg_index == CFG_END);
	end

	psv_map_ram #(
		.ADDR_BITS (MAP_AW),
		.DATA_BITS (1)
	) u_map (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (qoff[MAP_AW:1]),
		.rdata (rd_data)
	);

	psv_sieve_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (run_acc),
		.range_begin (begin_q),
		.range_end   (end_q),
		.slot_free   (slot_free),
		.busy        (ctrl_busy),
		.done        (done),
		.wr          (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_q     <= BEGIN_RESET;
			end_q       <= END_RESET;
			win_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write && cfg_index == CFG_BEGIN) begin
				begin_q <= cfg_data;
			end
			if (cfg_write && cfg_index == CFG_END) begin
				end_q <= cfg_data;
			end

			if (cfg_hit || run_acc) begin
				win_valid_q <= 1'b0;
			end else if (done.valid && done.status == ST_OK) begin
				win_valid_q <= 1'b1;
			end

			if (q_acc || done.valid) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end

			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_acc) begin
			status_s1 <= in_win ? ST_OK : ST_OUTSIDE;
			odd_s1    <= in_win && query_value[0];
		end else if (done.valid) begin
			status_s1 <= done.status;
			odd_s1    <= 1'b0;
		end
		if (adv) begin
			is_prime_q <= odd_s1 && rd_data;
			status_q   <= status_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;
	assign status    = status_q;

	a_run_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_busy |-> in_stall)
		else $error("input taken during a run");

	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> !rd_en)
		else $error("map written and queried in one cycle");

	a_prime_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_prime |-> status == ST_OK)
		else $error("prime word with error status");

endmodule

`default_nettype wire
